>>> design/plt_pkg.sv
`default_nettype none
package plt_pkg;

    localparam int DATA_W = 32;

    // Operation codes.
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]               op;
        logic [5:0]               position;
        logic signed [DATA_W-1:0] value;
    } plt_req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [5:0]               count;
    } plt_rsp_t;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic append_en;
        logic insert_en;
        logic delete_en;
        logic read_en;
    } plt_cmd_t;

endpackage
`default_nettype wire

>>> design/plt_cell.sv
`default_nettype none
module plt_cell import plt_pkg::*; #(
    parameter int IDX_W = 5,
    parameter int IDX   = 0
) (
    input  wire logic              aclk,
    input  wire plt_cmd_t          cmd,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] data,
    output logic      [DATA_W-1:0] rd_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_index;
    logic              above_index;

    assign at_index    = (MY_IDX == index);
    assign above_index = (MY_IDX > index);

    always_comb begin
        data_next = data_reg;
        priority if (cmd.append_en && at_index) begin
            data_next = value;
        end else if (cmd.insert_en && at_index) begin
            data_next = value;
        end else if (cmd.insert_en && above_index) begin
            // shift up: take the lower neighbor
            data_next = left_data;
        end else if (cmd.delete_en && (at_index || above_index)) begin
            // shift down: take the upper neighbor
            data_next = right_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = at_index ? data_reg : '0;

endmodule
`default_nettype wire

>>> design/plt_ctrl.sv
`default_nettype none
module plt_ctrl import plt_pkg::*; #(
    parameter int CAPACITY = 32,
    parameter int IDX_W    = 5,
    parameter int CNT_W    = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [2:0]       op,
    input  wire logic [5:0]       position,
    output plt_cmd_t              cmd,
    output logic [IDX_W-1:0]      index,
    output logic [1:0]            status,
    output logic [CNT_W-1:0]      count_next
);

    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] used_count_reg;
    logic [CNT_W-1:0] used_count_next;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [5:0]       pos_m1;
    logic             is_full;
    logic             is_empty;
    logic             bad_pos;
    plt_cmd_t         dec;

    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(used_count_reg);
    assign pos_m1   = position - 6'd1;
    assign is_full  = (used_count_reg >= CAP);
    assign is_empty = (used_count_reg == '0);
    assign bad_pos  = (position == 6'd0) || (pos_ext > cnt_ext);

    always_comb begin
        dec             = '0;
        status          = ST_OK;
        used_count_next = used_count_reg;
        index           = IDX_W'(pos_m1);
        unique case (op)
            OP_CLEAR: begin
                used_count_next = '0;
            end
            OP_APPEND: begin
                index = IDX_W'(used_count_reg);
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    dec.append_en   = 1'b1;
                    used_count_next = used_count_reg + CNT_W'(1);
                end
            end
            OP_INSERT, OP_DELETE, OP_READ: begin
                priority if (is_empty) begin
                    status = ST_EMPTY;
                end else if (bad_pos) begin
                    status = ST_BADPOS;
                end else if (op == OP_INSERT) begin
                    if (is_full) begin
                        status = ST_FULL;
                    end else begin
                        dec.insert_en   = 1'b1;
                        used_count_next = used_count_reg + CNT_W'(1);
                    end
                end else if (op == OP_DELETE) begin
                    dec.delete_en   = 1'b1;
                    used_count_next = used_count_reg - CNT_W'(1);
                end else begin
                    dec.read_en = 1'b1;
                end
            end
            default: begin
                // undefined code: no operation
            end
        endcase
    end

    assign cmd        = accept ? dec : '0;
    assign count_next = used_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_count_reg <= '0;
        end else if (accept) begin
            used_count_reg <= used_count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= CAP)
        else $error("element count above capacity");

    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && status != ST_OK) |=> used_count_reg == $past(used_count_reg))
        else $error("refused request changed the count");

    a_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.append_en || cmd.insert_en) |=>
            used_count_reg == $past(used_count_reg) + CNT_W'(1))
        else $error("append or insert did not grow the list by one");

    a_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.delete_en |=> used_count_reg == $past(used_count_reg) - CNT_W'(1))
        else $error("delete did not shrink the list by one");

endmodule
`default_nettype wire

>>> design/positional_list_insert_delete_top.sv
// Positional list: an ordered list of up to CAPACITY signed 32-bit values,
// addressed by 1-based position.
// Input channel (s_valid / s_ready / s_data): one request per operation,
// clear, append, insert, delete or read, with position and value fields.
// Result channel (m_valid / m_ready / m_data): exactly one response per
// request carrying status, the value read and the list length afterwards.
// The response register loads when the request is accepted. Throughput: one
// request per cycle unless stalled. Every entry sits in its own cell of a
// chain, and insert or delete moves all affected cells to their neighbor in
// the same cycle; the read port is an AND-OR select across the cells.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// response; entry contents are not cleared and are never visible unwritten.
// When the receiver stalls, the response register holds its data and
// s_ready goes low until the response is taken; a new request is accepted in
// the same cycle that the pending response leaves.
`default_nettype none
module positional_list_insert_delete_top import plt_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire plt_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output plt_rsp_t      m_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                              accept;
    plt_cmd_t                          cmd;
    logic [IDX_W-1:0]                  index;
    logic [1:0]                        status;
    logic [CNT_W-1:0]                  count_next;
    logic [CAPACITY-1:0][DATA_W-1:0]   cell_data;
    logic [CAPACITY-1:0][DATA_W-1:0]   cell_rd;
    logic [DATA_W-1:0]                 rd_any;

    logic     m_valid_reg;
    logic     m_valid_next;
    plt_rsp_t m_data_reg;
    plt_rsp_t m_data_next;

    // Take a new request whenever the response slot is empty or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    plt_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (s_data.op),
        .position   (s_data.position),
        .cmd        (cmd),
        .index      (index),
        .status     (status),
        .count_next (count_next)
    );

    // Chain of entry cells; the ends see zero as their missing neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        plt_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .index      (index),
            .value      (s_data.value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Merge the selected cell onto the read bus.
    always_comb begin
        rd_any = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            rd_any = rd_any | cell_rd[j];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            // load the response for this request
            m_valid_next           = 1'b1;
            m_data_next.status     = status;
            m_data_next.read_value = cmd.read_en ? rd_any : '0;
            m_data_next.count      = 6'(count_next);
        end else if (m_ready) begin
            // response taken, slot empties
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
    import plt_pkg::*;

    localparam int LIST_CAP    = 32;
    localparam int RAND_ITEMS  = 1550;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 250;
    localparam int DRAIN_WAIT  = 8;

    // Op codes the block must treat as no operation.
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Random op mix: grow the list toward full, drain it, or a bit of both.
    typedef enum logic [1:0] {MIX_OPS, GROW_LIST, SHRINK_LIST} op_mix_t;

    // One row of the directed table. Rows with known set carry a response
    // read straight off the spec; the rest are checked against the predictor.
    typedef struct packed {
        plt_req_t   req;
        logic [7:0] reps;
        logic       rand_val;
        logic       known;
        plt_rsp_t   rsp;
    } list_step_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    plt_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    plt_rsp_t m_data;

    // Side band that travels with each request: a typed-in response, if any.
    logic     req_known     = 1'b0;
    plt_rsp_t req_known_rsp = '0;

    // Predictor state: a mirror of the list contents and length.
    logic signed [DATA_W-1:0] list_mem [LIST_CAP];
    int                       list_len = 0;

    plt_rsp_t   awaited_results [$];
    list_step_t step_table [$];

    int       error_count = 0;
    int       cycle_count = 0;
    plt_rsp_t head_rsp;
    plt_rsp_t predicted_rsp;

    // Receiver pacing.
    logic long_hold_start = 1'b0;
    int   long_hold_left  = 0;
    int   rx_gap_left     = 0;
    int   rx_cycle        = 0;
    logic rx_quiet        = 1'b0;

    positional_list_insert_delete_top #(.CAPACITY(LIST_CAP)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one operation to the mirrored list and return its response.
    // For insert, delete and read, empty comes first, then the position range, then full (insert only).
    function automatic plt_rsp_t apply_list_op(input plt_req_t req);
        plt_rsp_t rsp;
        int       pos;
        int       i;
        rsp            = '0;
        rsp.status     = ST_OK;
        pos            = req.position;
        case (req.op)
            OP_CLEAR: begin
                // Only the length drops; stale entries stay but are unreachable.
                list_len = 0;
            end
            OP_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_mem[list_len] = req.value;
                    list_len++;
                end
            end
            OP_INSERT, OP_DELETE, OP_READ: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (pos < 1 || pos > list_len) begin
                    rsp.status = ST_BADPOS;
                end else if (req.op == OP_INSERT) begin
                    if (list_len >= LIST_CAP) begin
                        rsp.status = ST_FULL;
                    end else begin
                        // Shift the tail up by one and drop the value in.
                        for (i = list_len; i >= pos; i--) list_mem[i] = list_mem[i-1];
                        list_mem[pos-1] = req.value;
                        list_len++;
                    end
                end else if (req.op == OP_DELETE) begin
                    for (i = pos - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end else begin
                    rsp.read_value = list_mem[pos-1];
                end
            end
            default: begin
                // Reserved codes leave the list alone.
            end
        endcase
        rsp.count = 6'(list_len);
        return rsp;
    endfunction

    // Idle length: mostly none, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 6);
    endfunction

    // Build a random request; positions mostly land inside the current list.
    function automatic plt_req_t pick_request(input op_mix_t mix);
        plt_req_t req;
        int       r;
        int       pos;
        r = $urandom_range(99);
        case (mix)
            GROW_LIST: begin
                if (r < 45)      req.op = OP_APPEND;
                else if (r < 75) req.op = OP_INSERT;
                else if (r < 87) req.op = OP_READ;
                else if (r < 97) req.op = OP_DELETE;
                else             req.op = OP_RSVD5;
            end
            SHRINK_LIST: begin
                if (r < 50)      req.op = OP_DELETE;
                else if (r < 72) req.op = OP_READ;
                else if (r < 84) req.op = OP_INSERT;
                else if (r < 96) req.op = OP_APPEND;
                else             req.op = OP_RSVD6;
            end
            default: begin
                if (r < 25)      req.op = OP_DELETE;
                else if (r < 50) req.op = OP_INSERT;
                else if (r < 65) req.op = OP_APPEND;
                else if (r < 94) req.op = OP_READ;
                else if (r < 97) req.op = OP_CLEAR;
                else             req.op = OP_RSVD5 + 3'($urandom_range(2));
            end
        endcase
        r = $urandom_range(99);
        if (list_len > 0 && r < 85) pos = $urandom_range(list_len, 1);
        else if (r < 92)             pos = list_len + 1;
        else                         pos = $urandom_range(63);
        req.position = 6'(pos);
        case ($urandom_range(19))
            0:       req.value = 32'sh7fffffff;
            1:       req.value = 32'sh80000000;
            2:       req.value = '0;
            3:       req.value = -1;
            default: req.value = $urandom;
        endcase
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("t=%0t mismatch in %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic row_known(input logic [2:0] op, input logic [5:0] pos,
                             input logic signed [31:0] value, input logic [1:0] status,
                             input logic signed [31:0] rd, input logic [5:0] count);
        list_step_t step;
        step.req      = '{op: op, position: pos, value: value};
        step.reps     = 8'd1;
        step.rand_val = 1'b0;
        step.known    = 1'b1;
        step.rsp      = '{status: status, read_value: rd, count: count};
        step_table.push_back(step);
    endtask

    task automatic row_predicted(input logic [2:0] op, input logic [5:0] pos,
                                 input logic signed [31:0] value, input int reps,
                                 input logic rand_val);
        list_step_t step;
        step.req      = '{op: op, position: pos, value: value};
        step.reps     = 8'(reps);
        step.rand_val = rand_val;
        step.known    = 1'b0;
        step.rsp      = '0;
        step_table.push_back(step);
    endtask

    // Offer one request after an idle stretch and hold it until accepted.
    // Valid stays high on return so a back-to-back request keeps it up.
    task automatic offer_request(input plt_req_t req, input logic known,
                                 input plt_rsp_t known_rsp, input int idle);
        repeat (idle) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_data        <= req;
        req_known     <= known;
        req_known_rsp <= known_rsp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering and wait for every outstanding response to come back.
    task automatic drain_results;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold on request.
    always @(negedge aclk) begin
        if (long_hold_start) begin
            long_hold_start = 1'b0;
            long_hold_left  = LONG_HOLD;
        end
        rx_cycle++;
        if (rx_cycle % 150 == 0) rx_quiet = ($urandom_range(2) == 0);
        if (long_hold_left > 0) begin
            long_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready     <= 1'b1;
            rx_gap_left = pick_gap(rx_quiet);
        end
    end

    // Scoreboard: check the response leaving this edge against the oldest
    // expectation, then predict the request accepted on the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected response", 32'(m_data), '0);
                end else begin
                    head_rsp = awaited_results.pop_front();
                    if (m_data.status !== head_rsp.status)
                        report_mismatch("status", 32'(m_data.status), 32'(head_rsp.status));
                    if (m_data.read_value !== head_rsp.read_value)
                        report_mismatch("read_value", m_data.read_value,
                                        head_rsp.read_value);
                    if (m_data.count !== head_rsp.count)
                        report_mismatch("count", 32'(m_data.count), 32'(head_rsp.count));
                end
            end
            if (s_valid && s_ready) begin
                predicted_rsp = apply_list_op(s_data);
                awaited_results.push_back(req_known ? req_known_rsp : predicted_rsp);
            end
        end
    end

    // Stimulus: reset, the directed table, then random traffic.
    initial begin : stimulus
        plt_req_t   req;
        list_step_t step;
        op_mix_t    mix;
        logic       tx_quiet;
        int         n;

        mix      = MIX_OPS;
        tx_quiet = 1'b0;

        // Empty list: every positional op is refused as empty.
        row_known(OP_READ,   6'd1, 0, ST_EMPTY, 0, 6'd0);
        row_known(OP_DELETE, 6'd1, 0, ST_EMPTY, 0, 6'd0);
        row_known(OP_INSERT, 6'd1, 5, ST_EMPTY, 0, 6'd0);
        // Value extremes in and back out.
        row_known(OP_APPEND, 6'd0, 32'sh7fffffff, ST_OK, 0, 6'd1);
        row_known(OP_APPEND, 6'd0, 32'sh80000000, ST_OK, 0, 6'd2);
        row_known(OP_READ,   6'd1, 0, ST_OK, 32'sh7fffffff, 6'd2);
        row_known(OP_READ,   6'd2, 0, ST_OK, 32'sh80000000, 6'd2);
        // Position range: zero, one past the end, all ones.
        row_known(OP_READ,   6'd0,  0, ST_BADPOS, 0, 6'd2);
        row_known(OP_READ,   6'd3,  0, ST_BADPOS, 0, 6'd2);
        row_known(OP_INSERT, 6'd63, -1, ST_BADPOS, 0, 6'd2);
        row_known(OP_INSERT, 6'd1, -1, ST_OK, 0, 6'd3);
        row_known(OP_READ,   6'd1,  0, ST_OK, -1, 6'd3);
        row_known(OP_DELETE, 6'd3,  0, ST_OK, 0, 6'd2);
        row_known(OP_DELETE, 6'd0,  0, ST_BADPOS, 0, 6'd2);
        // Reserved codes are no-ops.
        row_known(OP_RSVD5, 6'd63, -1, ST_OK, 0, 6'd2);
        row_known(OP_RSVD6, 6'd1,  -1, ST_OK, 0, 6'd2);
        row_known(OP_RSVD7, 6'd2,  -1, ST_OK, 0, 6'd2);
        // Fill to capacity, then hit the full and range checks at the top.
        row_predicted(OP_APPEND, 6'd0, 0, LIST_CAP - 2, 1'b1);
        row_known(OP_APPEND, 6'd0,  0, ST_FULL, 0, 6'd32);
        row_known(OP_INSERT, 6'd32, 1, ST_FULL, 0, 6'd32);
        row_known(OP_INSERT, 6'd33, 1, ST_BADPOS, 0, 6'd32);
        row_predicted(OP_READ,   6'd32, 0, 1, 1'b0);
        row_known(OP_DELETE, 6'd32, 0, ST_OK, 0, 6'd31);
        row_predicted(OP_INSERT, 6'd31, 0, 1, 1'b1);
        row_known(OP_DELETE, 6'd1,  0, ST_OK, 0, 6'd31);
        row_predicted(OP_READ,   6'd1,  0, 1, 1'b0);
        // Clear leaves stale entries that must stay out of reach.
        row_known(OP_CLEAR,  6'd0,  0, ST_OK, 0, 6'd0);
        row_known(OP_READ,   6'd1,  0, ST_EMPTY, 0, 6'd0);
        row_known(OP_APPEND, 6'd0,  0, ST_OK, 0, 6'd1);
        row_known(OP_READ,   6'd1,  0, ST_OK, 0, 6'd1);

        // Hold reset, then release it once.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table.
        foreach (step_table[k]) begin
            step = step_table[k];
            for (n = 0; n < step.reps; n++) begin
                req = step.req;
                if (step.rand_val) req.value = $urandom;
                offer_request(req, step.known, step.rsp, pick_gap(1'b0));
            end
        end
        drain_results();

        // Random traffic in phases of different op mixes.
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) mix = op_mix_t'($urandom_range(2));
            if (n % 100 == 0) tx_quiet = ($urandom_range(3) == 0);
            // Stall the receiver for a long stretch while requests keep coming.
            if (n == 500) long_hold_start = 1'b1;
            // Pause the sender until every response is back.
            if (n == 1000) drain_results();
            req = pick_request(mix);
            offer_request(req, 1'b0, '0, pick_gap(tx_quiet));
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait out the remaining responses, then keep watching for strays.
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
